// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL core.
// No dependencies; NO_ASSERTIONS removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/mrf_pkg.sv =====
// Types, codes and the CRC-16/Modbus step for the Modbus RTU master framer.
// No dependencies.
`timescale 1ns / 1ps
package mrf_pkg;

	localparam logic [1:0] CMD_READ    = 2'd0;
	localparam logic [1:0] CMD_WRITE   = 2'd1;
	localparam logic [1:0] CMD_RX      = 2'd2;
	localparam logic [1:0] CMD_TIMEOUT = 2'd3;

	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_REG    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_BAD_REQ = 3'd1;
	localparam logic [2:0] ST_ADDR    = 3'd2;
	localparam logic [2:0] ST_EXC     = 3'd3;
	localparam logic [2:0] ST_FUNC    = 3'd4;
	localparam logic [2:0] ST_COUNT   = 3'd5;
	localparam logic [2:0] ST_CRC     = 3'd6;
	localparam logic [2:0] ST_TIMEOUT = 3'd7;

	localparam logic [1:0] PH_IDLE     = 2'd0;
	localparam logic [1:0] PH_COLLECT  = 2'd1;
	localparam logic [1:0] PH_RX_READ  = 2'd2;
	localparam logic [1:0] PH_RX_WRITE = 2'd3;

	localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
	localparam logic [1:0] CFG_READ_FC    = 2'd1;

	localparam logic [7:0]  FC_WRITE_ONE   = 8'd6;
	localparam logic [7:0]  FC_WRITE_MANY  = 8'd16;
	localparam logic [7:0]  EXC_FLAG       = 8'h80;
	localparam logic [7:0]  MAX_READ_REGS  = 8'd125;
	localparam logic [7:0]  MAX_WRITE_REGS = 8'd123;
	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY       = 16'hA001;
	localparam logic [7:0]  SLAVE_ADDR_RST = 8'd1;
	localparam logic [7:0]  READ_FC_RST    = 8'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] reg_address;
		logic [7:0]  reg_count;
		logic [15:0] word_value;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx_byte;
		logic [15:0] reg_value;
		logic [2:0]  status;
		logic        last;
	} res_t;

	function automatic logic [15:0] crc_step(input logic [15:0] c_in, input logic [7:0] b);
		logic [15:0] c;
		c = c_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/mrf_in_reg.sv =====
// Input holding register: keeps one accepted item until the engine pops it.
// Depends on mrf_pkg.
`timescale 1ns / 1ps
module mrf_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [47:0]       s_tdata,
	input  logic [1:0]        s_tuser,
	input  logic              pop,
	output logic              item_valid,
	output mrf_pkg::item_t    item
);

	logic           full_q;
	mrf_pkg::item_t item_q;

	assign s_tready   = !full_q || pop;
	assign item_valid = full_q;
	assign item       = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			full_q <= 1'b1;
		end else if (pop) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_q.cmd         <= s_tuser;
			item_q.reg_address <= s_tdata[15:0];
			item_q.reg_count   <= s_tdata[23:16];
			item_q.word_value  <= s_tdata[39:24];
			item_q.rx_byte     <= s_tdata[47:40];
		end
	end

endmodule

// ===== rtl/core/mrf_engine.sv =====
// Framing and response-check engine: decodes the held item, steps through its
// results one per cycle while res_ready is high and keeps the transaction state. Depends on mrf_pkg.
`timescale 1ns / 1ps
module mrf_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              item_valid,
	input  mrf_pkg::item_t    item,
	output logic              pop,
	output logic              res_valid,
	output mrf_pkg::res_t     res,
	input  logic              res_ready
);

	localparam logic [2:0] FR_NONE     = 3'd0;
	localparam logic [2:0] FR_STATUS   = 3'd1;
	localparam logic [2:0] FR_REGVAL   = 3'd2;
	localparam logic [2:0] FR_READ     = 3'd3;
	localparam logic [2:0] FR_W1       = 3'd4;
	localparam logic [2:0] FR_WM       = 3'd5;
	localparam logic [2:0] FR_WORD     = 3'd6;
	localparam logic [2:0] FR_WORD_END = 3'd7;

	logic [7:0]  sa_q, rfc_q;
	logic [1:0]  phase_q;
	logic [15:0] crc_q;
	logic [7:0]  fpend_q;
	logic [6:0]  regs_exp_q;
	logic [6:0]  word_idx_q;
	logic [7:0]  rx_idx_q;
	logic [7:0]  bytes_exp_q;
	logic [7:0]  data_high_q;
	logic [7:0]  crc_low_q;
	logic [2:0]  fault_q;
	logic [3:0]  step_q;

	logic [7:0]  cnt, b;
	logic        rd_bad, wr_bad, wi_end, rx_phase, rx_body, rx_crclo, rx_word;
	logic [6:0]  wi_next;
	logic [8:0]  idx_p2;
	logic [2:0]  det, rx_st, st_code, fr;
	logic        restart, is_crc, fire, last_hit;
	logic [3:0]  n_res, last_step;
	logic [15:0] crc_cur;
	logic [7:0]  tb [9];
	logic [7:0]  tx_sel;

	assign cnt      = item.reg_count;
	assign b        = item.rx_byte;
	assign rd_bad   = (cnt == 8'd0) || (cnt > mrf_pkg::MAX_READ_REGS);
	assign wr_bad   = (cnt == 8'd0) || (cnt > mrf_pkg::MAX_WRITE_REGS);
	assign wi_next  = word_idx_q + 7'd1;
	assign wi_end   = wi_next >= regs_exp_q;
	assign rx_phase = (phase_q == mrf_pkg::PH_RX_READ) || (phase_q == mrf_pkg::PH_RX_WRITE);
	assign idx_p2   = {1'b0, rx_idx_q} + 9'd2;
	assign rx_body  = idx_p2 < {1'b0, bytes_exp_q};
	assign rx_crclo = idx_p2 == {1'b0, bytes_exp_q};
	assign rx_word  = (phase_q == mrf_pkg::PH_RX_READ) && (rx_idx_q >= 8'd4) && !rx_idx_q[0];

	// first failing header check for this byte
	always_comb begin
		det = mrf_pkg::ST_OK;
		if (rx_idx_q == 8'd0) begin
			if (b != sa_q) det = mrf_pkg::ST_ADDR;
		end else if (rx_idx_q == 8'd1) begin
			if (phase_q == mrf_pkg::PH_RX_WRITE) begin
				if (b == (fpend_q | mrf_pkg::EXC_FLAG)) det = mrf_pkg::ST_EXC;
				else if (b != fpend_q) det = mrf_pkg::ST_FUNC;
			end else if (b != rfc_q) begin
				det = mrf_pkg::ST_FUNC;
			end
		end else if ((rx_idx_q == 8'd2) && (phase_q == mrf_pkg::PH_RX_READ)) begin
			if (b != {regs_exp_q, 1'b0}) det = mrf_pkg::ST_COUNT;
		end
	end

	assign rx_st = (fault_q != mrf_pkg::ST_OK) ? fault_q :
		(({b, crc_low_q} != crc_q) ? mrf_pkg::ST_CRC : mrf_pkg::ST_OK);

	always_comb begin
		fr      = FR_NONE;
		st_code = mrf_pkg::ST_OK;
		restart = 1'b0;
		unique case (item.cmd)
			mrf_pkg::CMD_READ: begin
				restart = 1'b1;
				fr      = rd_bad ? FR_STATUS : FR_READ;
				st_code = mrf_pkg::ST_BAD_REQ;
			end
			mrf_pkg::CMD_WRITE: begin
				if (phase_q == mrf_pkg::PH_COLLECT) begin
					fr = wi_end ? FR_WORD_END : FR_WORD;
				end else begin
					restart = 1'b1;
					st_code = mrf_pkg::ST_BAD_REQ;
					if (wr_bad) fr = FR_STATUS;
					else if (cnt == 8'd1) fr = FR_W1;
					else fr = FR_WM;
				end
			end
			mrf_pkg::CMD_RX: begin
				if (rx_phase) begin
					if (rx_body) begin
						if (rx_word) fr = FR_REGVAL;
					end else if (!rx_crclo) begin
						fr      = FR_STATUS;
						st_code = rx_st;
					end
				end
			end
			mrf_pkg::CMD_TIMEOUT: begin
				if (phase_q != mrf_pkg::PH_IDLE) begin
					fr      = FR_STATUS;
					st_code = mrf_pkg::ST_TIMEOUT;
				end
			end
			default: fr = FR_NONE;
		endcase
	end

	always_comb begin
		case (fr)
			FR_STATUS, FR_REGVAL:   n_res = 4'd1;
			FR_READ, FR_W1:         n_res = 4'd8;
			FR_WM:                  n_res = 4'd9;
			FR_WORD:                n_res = 4'd2;
			FR_WORD_END:            n_res = 4'd4;
			default:                n_res = 4'd0;
		endcase
	end
	assign last_step = n_res - 4'd1;

	assign crc_cur = ((step_q == 4'd0) && restart) ? mrf_pkg::CRC_INIT : crc_q;

	always_comb begin
		for (int i = 0; i < 9; i++) tb[i] = 8'h00;
		case (fr)
			FR_READ: begin
				tb[0] = sa_q;
				tb[1] = rfc_q;
				tb[2] = item.reg_address[15:8];
				tb[3] = item.reg_address[7:0];
				tb[5] = cnt;
				tb[6] = crc_cur[7:0];
				tb[7] = crc_cur[15:8];
			end
			FR_W1: begin
				tb[0] = sa_q;
				tb[1] = mrf_pkg::FC_WRITE_ONE;
				tb[2] = item.reg_address[15:8];
				tb[3] = item.reg_address[7:0];
				tb[4] = item.word_value[15:8];
				tb[5] = item.word_value[7:0];
				tb[6] = crc_cur[7:0];
				tb[7] = crc_cur[15:8];
			end
			FR_WM: begin
				tb[0] = sa_q;
				tb[1] = mrf_pkg::FC_WRITE_MANY;
				tb[2] = item.reg_address[15:8];
				tb[3] = item.reg_address[7:0];
				tb[5] = cnt;
				tb[6] = {cnt[6:0], 1'b0};
				tb[7] = item.word_value[15:8];
				tb[8] = item.word_value[7:0];
			end
			FR_WORD, FR_WORD_END: begin
				tb[0] = item.word_value[15:8];
				tb[1] = item.word_value[7:0];
				tb[2] = crc_cur[7:0];
				tb[3] = crc_cur[15:8];
			end
			default: tb[0] = 8'h00;
		endcase
	end
	assign tx_sel = tb[step_q];

	assign is_crc = (((fr == FR_READ) || (fr == FR_W1)) && (step_q >= 4'd6)) ||
		((fr == FR_WORD_END) && (step_q >= 4'd2));

	always_comb begin
		res.kind      = mrf_pkg::KIND_TX;
		res.tx_byte   = tx_sel;
		res.reg_value = 16'h0000;
		res.status    = mrf_pkg::ST_OK;
		if (fr == FR_STATUS) begin
			res.kind    = mrf_pkg::KIND_STATUS;
			res.tx_byte = 8'h00;
			res.status  = st_code;
		end else if (fr == FR_REGVAL) begin
			res.kind      = mrf_pkg::KIND_REG;
			res.tx_byte   = 8'h00;
			res.reg_value = {data_high_q, b};
		end
		res.last = last_hit;
	end

	assign last_hit  = step_q == last_step;
	assign res_valid = item_valid && (fr != FR_NONE);
	assign fire      = res_valid && res_ready;
	assign pop       = item_valid && ((fr == FR_NONE) || (fire && last_hit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sa_q <= mrf_pkg::SLAVE_ADDR_RST;
			rfc_q <= mrf_pkg::READ_FC_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mrf_pkg::CFG_SLAVE_ADDR: sa_q  <= cfg_data;
				mrf_pkg::CFG_READ_FC:    rfc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= mrf_pkg::PH_IDLE;
			crc_q       <= mrf_pkg::CRC_INIT;
			fpend_q     <= 8'h00;
			regs_exp_q  <= 7'd0;
			word_idx_q  <= 7'd0;
			rx_idx_q    <= 8'd0;
			bytes_exp_q <= 8'd0;
			data_high_q <= 8'h00;
			crc_low_q   <= 8'h00;
			fault_q     <= mrf_pkg::ST_OK;
			step_q      <= 4'd0;
		end else begin
			if (fire) begin
				step_q <= last_hit ? 4'd0 : step_q + 4'd1;
				if ((res.kind == mrf_pkg::KIND_TX) && !is_crc) begin
					crc_q <= mrf_pkg::crc_step(crc_cur, tx_sel);
				end
			end
			if (pop) begin
				case (fr)
					FR_STATUS: begin
						phase_q <= mrf_pkg::PH_IDLE;
						crc_q   <= mrf_pkg::CRC_INIT;
					end
					FR_READ: begin
						regs_exp_q  <= cnt[6:0];
						phase_q     <= mrf_pkg::PH_RX_READ;
						bytes_exp_q <= 8'd5 + {cnt[6:0], 1'b0};
						rx_idx_q    <= 8'd0;
						fault_q     <= mrf_pkg::ST_OK;
						crc_q       <= mrf_pkg::CRC_INIT;
					end
					FR_W1, FR_WORD_END: begin
						if (fr == FR_W1) fpend_q <= mrf_pkg::FC_WRITE_ONE;
						else word_idx_q <= wi_next;
						phase_q     <= mrf_pkg::PH_RX_WRITE;
						bytes_exp_q <= 8'd8;
						rx_idx_q    <= 8'd0;
						fault_q     <= mrf_pkg::ST_OK;
						crc_q       <= mrf_pkg::CRC_INIT;
					end
					FR_WM: begin
						fpend_q    <= mrf_pkg::FC_WRITE_MANY;
						regs_exp_q <= cnt[6:0];
						word_idx_q <= 7'd1;
						phase_q    <= mrf_pkg::PH_COLLECT;
					end
					FR_WORD: word_idx_q <= wi_next;
					default: begin
						// response byte in the body or the CRC low byte
						if ((item.cmd == mrf_pkg::CMD_RX) && rx_phase) begin
							if (rx_body) begin
								crc_q    <= mrf_pkg::crc_step(crc_q, b);
								rx_idx_q <= rx_idx_q + 8'd1;
								if ((fault_q == mrf_pkg::ST_OK) && (det != mrf_pkg::ST_OK)) begin
									fault_q <= det;
								end
								if ((phase_q == mrf_pkg::PH_RX_READ) && (rx_idx_q >= 8'd3) &&
									rx_idx_q[0]) begin
									data_high_q <= b;
								end
							end else if (rx_crclo) begin
								crc_low_q <= b;
								rx_idx_q  <= rx_idx_q + 8'd1;
							end
						end
					end
				endcase
			end
		end
	end

endmodule

// ===== rtl/core/mrf_out_reg.sv =====
// Result register: holds one result for the master side; the engine is stalled
// while a held result waits with m_tready low. Depends on mrf_pkg.
`timescale 1ns / 1ps
module mrf_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  mrf_pkg::res_t     res,
	output logic              res_ready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,
	output logic [1:0]        m_tuser,
	output logic              m_tlast
);

	logic          valid_q;
	mrf_pkg::res_t res_q;

	assign res_ready = !valid_q || m_tready;
	assign m_tvalid  = valid_q;
	assign m_tdata   = {5'd0, res_q.status, res_q.reg_value, res_q.tx_byte};
	assign m_tuser   = res_q.kind;
	assign m_tlast   = res_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

endmodule

// ===== rtl/core/modbus_rtu_master_framer.sv =====
// Modbus RTU master framer, top level: input register, engine, result register.
// Depends on mrf_pkg, mrf_in_reg, mrf_engine, mrf_out_reg and assert_macros.svh.
//
// Requests (read, write word) and received response bytes come in on the
// s_ stream with the command in s_tuser; frame bytes, register values and
// statuses leave on the m_ stream with the result kind in m_tuser and tlast on
// the final result of each input transaction. One result leaves per cycle
// through the result register while m_tready is high: a read request or a
// single-word write gives 8 results, the first word of a multi-word write 9,
// each later word 2 (4 with the CRC), a response byte or timeout at most 1.
// The next item is taken in the cycle its predecessor's last result is loaded;
// CRC-16/Modbus steps over each emitted byte. The configuration port is always ready.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module modbus_rtu_master_framer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // reg_address, reg_count, word_value, rx_byte
	input  logic [1:0]  s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // tx_byte, reg_value, status, zero fill
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic           item_valid, in_pop, res_valid, res_ready;
	logic           single_res;
	mrf_pkg::item_t item;
	mrf_pkg::res_t  res;

	assign cfg_ready  = 1'b1;
	assign single_res = m_tvalid && (m_tuser != mrf_pkg::KIND_TX);

	mrf_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.pop        (in_pop),
		.item_valid (item_valid),
		.item       (item)
	);

	mrf_engine u_eng (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item       (item),
		.pop        (in_pop),
		.res_valid  (res_valid),
		.res        (res),
		.res_ready  (res_ready)
	);

	mrf_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid),
		.res        (res),
		.res_ready  (res_ready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	`ASSERT_IMPLIES(a_pop_needs_item, clk, arst_n, in_pop, item_valid, "pop without held item")
	`ASSERT_NEXT(a_result_loaded, clk, arst_n, res_valid && res_ready, m_tvalid, "result lost")
	`ASSERT_IMPLIES(a_status_is_last, clk, arst_n, single_res, m_tlast, "lone result not last")

endmodule
